@@ sv/aarm_pkg.sv @@
// Shared types and constants for the axis-angle to rotation matrix core.
// Holds the angle conversion table, the CORDIC arctangent table and the gain.
// No dependencies.
package aarm_pkg;

    // Width of every input and output field.
    localparam int FIELD_W = 16;

    // Guard bits carried beyond FRAC_BITS inside the datapath.
    localparam int GUARD_BITS = 4;

    // Binary angle and CORDIC angle accumulator widths.
    localparam int BA_W = 32;
    localparam int ZW   = 33;

    // Half angle conversion: ba = floor((angle + DEG_OFFSET) * 2^DEG_SHIFT / 45 + 22/45).
    localparam int DEG_OFFSET = 46080;
    localparam int DEG_SHIFT  = 22;
    localparam int DEG_DIV    = 45;
    localparam int DEG_ROUND  = 22;

    // Width of the offset angle and the reciprocal used to divide it by 45.
    localparam int N_W         = 17;
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_MUL   = (2 ** RECIP_SHIFT) / DEG_DIV;
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = N_W + RECIP_W;
    localparam int Q_W         = 11;
    localparam int R_W         = 6;

    // CORDIC gain 0.60725293500888 in Q0.32.
    localparam logic [31:0] KINV_Q32 = 32'd2608131496;

    // Arctangent of 2^-i as a 32-bit binary angle.
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_W       = 31;

    typedef logic [ATAN_W-1:0] atan_tab_t [ATAN_ENTRIES];

    localparam atan_tab_t ATAN_TAB = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
        31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
        31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
        31'd166886,    31'd83443,     31'd41722,     31'd20861,
        31'd10430,     31'd5215,      31'd2608,      31'd1304,
        31'd652,       31'd326,       31'd163,       31'd81
    };

    // Fractional part of the binary angle for each remainder modulo 45.
    typedef logic [DEG_SHIFT-1:0] frac_tab_t [DEG_DIV];

    function automatic frac_tab_t make_frac_tab();
        frac_tab_t       tab;
        longint unsigned num;
        for (int r = 0; r < DEG_DIV; r++)
        begin
            num    = longint'(r) * (64'd1 << DEG_SHIFT) + longint'(DEG_ROUND);
            tab[r] = DEG_SHIFT'(num / DEG_DIV);
        end
        return tab;
    endfunction

    localparam frac_tab_t FRAC_TAB = make_frac_tab();

    // The three axis components travel together down the pipeline.
    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
    } axis_t;

endpackage

@@ sv/axis_angle_to_rotation_matrix_core.sv @@
// Axis-angle to 3x3 rotation matrix, fully pipelined fixed-point datapath.
// Depends on aarm_pkg for tables, constants and the axis bundle type.
//
//   Channel   Signals                               Direction  Handshake
//   request   start, busy, angle_deg, axis_x/y/z    in         taken when start & !busy
//   result    done, m00 .. m22                      out        one-cycle strobe on done
//
// A request is taken in every cycle; busy is always low.
// Each result passes in order through the angle conversion, the initial CORDIC
// stage and the CORDIC iterations, then through sign fix, axis scaling, products,
// rounding, sums and output saturation. Reset clears only the valid bits; nothing
// stalls.
module axis_angle_to_rotation_matrix_core #(
    parameter int FRAC_BITS     = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [aarm_pkg::FIELD_W-1:0]  angle_deg,
    input  logic signed [aarm_pkg::FIELD_W-1:0]  axis_x,
    input  logic signed [aarm_pkg::FIELD_W-1:0]  axis_y,
    input  logic signed [aarm_pkg::FIELD_W-1:0]  axis_z,
    output logic                                 done,
    output logic signed [aarm_pkg::FIELD_W-1:0]  m00,
    output logic signed [aarm_pkg::FIELD_W-1:0]  m01,
    output logic signed [aarm_pkg::FIELD_W-1:0]  m02,
    output logic signed [aarm_pkg::FIELD_W-1:0]  m10,
    output logic signed [aarm_pkg::FIELD_W-1:0]  m11,
    output logic signed [aarm_pkg::FIELD_W-1:0]  m12,
    output logic signed [aarm_pkg::FIELD_W-1:0]  m20,
    output logic signed [aarm_pkg::FIELD_W-1:0]  m21,
    output logic signed [aarm_pkg::FIELD_W-1:0]  m22
);
    import aarm_pkg::*;

    // Internal formats.
    localparam int INT_BITS = FRAC_BITS + GUARD_BITS;
    localparam int CW       = INT_BITS + 2;
    localparam int XW       = FIELD_W + GUARD_BITS + 1;
    localparam int MW       = (CW > XW + 1) ? CW : XW + 1;
    localparam int PW       = 2 * MW;
    localparam int SW       = PW + 2;
    localparam int SCW      = FIELD_W + CW;
    localparam int LAT      = CORDIC_STAGES + 9;

    localparam logic signed [CW-1:0]  X_INIT     = CW'(KINV_Q32 >> (32 - INT_BITS));
    localparam logic signed [SCW-1:0] SCALE_HALF = SCW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PW-1:0]  PROD_HALF  = PW'(1) <<< (INT_BITS - 1);
    localparam logic signed [SW-1:0]  ONE_Q      = SW'(1) <<< INT_BITS;
    localparam logic signed [SW-1:0]  OUT_HALF   = SW'(1) <<< (GUARD_BITS - 1);
    localparam logic signed [SW-1:0]  SAT_MAX    = SW'(2 ** (FIELD_W - 1) - 1);
    localparam logic signed [SW-1:0]  SAT_MIN    = -SW'(2 ** (FIELD_W - 1));
    localparam logic signed [ZW-1:0]  Z_QUARTER  = ZW'(2 ** 30);

    // Axis scaling: round(a * s / 2^FRAC_BITS).
    function automatic logic signed [XW-1:0] scale_mul(
        input logic signed [FIELD_W-1:0] a,
        input logic signed [CW-1:0]      s
    );
        logic signed [SCW-1:0] p;
        p = a * s + SCALE_HALF;
        return XW'(p >>> FRAC_BITS);
    endfunction

    // Product rounding back to INT_BITS fraction bits.
    function automatic logic signed [PW-1:0] round_ib(input logic signed [PW-1:0] p);
        return (p + PROD_HALF) >>> INT_BITS;
    endfunction

    // Drop the guard bits with rounding and saturate to the field width.
    function automatic logic signed [FIELD_W-1:0] sat_out(input logic signed [SW-1:0] e);
        logic signed [SW-1:0] v;
        v = (e + OUT_HALF) >>> GUARD_BITS;
        if (v > SAT_MAX)
        begin
            return FIELD_W'(SAT_MAX);
        end
        if (v < SAT_MIN)
        begin
            return FIELD_W'(SAT_MIN);
        end
        return FIELD_W'(v);
    endfunction

    // Requests are never refused.
    assign busy = 1'b0;

    // ---------------------------------------------------------------------
    // Stage 1: offset the angle and multiply by the reciprocal of 45.
    // ---------------------------------------------------------------------
    logic                       s1_v_reg;
    logic [N_W-1:0]             s1_n_reg;
    logic [PROD_W-1:0]          s1_prod_reg;
    axis_t                      s1_axis_reg;
    logic signed [N_W:0]        s1_n_wide;
    logic [N_W-1:0]             s1_n_next;

    assign s1_n_wide = (N_W + 1)'(angle_deg) + (N_W + 1)'(DEG_OFFSET);
    assign s1_n_next = s1_n_wide[N_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_n_reg    <= s1_n_next;
        s1_prod_reg <= PROD_W'(s1_n_next) * PROD_W'(RECIP_MUL);
        s1_axis_reg <= '{x: axis_x, y: axis_y, z: axis_z};
    end

    // ---------------------------------------------------------------------
    // Stage 2: quotient and remainder by 45 with one correction step.
    // ---------------------------------------------------------------------
    logic                 s2_v_reg;
    logic [Q_W-1:0]       s2_q_reg;
    logic [R_W-1:0]       s2_r_reg;
    axis_t                s2_axis_reg;
    logic [Q_W-1:0]       s2_q_est;
    logic [N_W-1:0]       s2_r_est;
    logic [Q_W-1:0]       s2_q_next;
    logic [R_W-1:0]       s2_r_next;

    always_comb
    begin
        s2_q_est = s1_prod_reg[RECIP_SHIFT +: Q_W];
        s2_r_est = s1_n_reg - N_W'(N_W'(s2_q_est) * N_W'(DEG_DIV));
        if (s2_r_est >= N_W'(DEG_DIV))
        begin
            s2_q_next = s2_q_est + Q_W'(1);
            s2_r_next = R_W'(s2_r_est - N_W'(DEG_DIV));
        end
        else
        begin
            s2_q_next = s2_q_est;
            s2_r_next = R_W'(s2_r_est);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_q_reg    <= s2_q_next;
        s2_r_reg    <= s2_r_next;
        s2_axis_reg <= s1_axis_reg;
    end

    // ---------------------------------------------------------------------
    // Stage 3: assemble the binary angle and fold it into [-90, 90) degrees.
    // ---------------------------------------------------------------------
    logic                  c_v_reg    [CORDIC_STAGES+1];
    logic signed [CW-1:0]  cx_reg     [CORDIC_STAGES+1];
    logic signed [CW-1:0]  cy_reg     [CORDIC_STAGES+1];
    logic signed [ZW-1:0]  z_reg      [CORDIC_STAGES+1];
    logic                  flip_reg   [CORDIC_STAGES+1];
    axis_t                 c_axis_reg [CORDIC_STAGES+1];

    logic [BA_W-1:0]       ba;
    logic [BA_W-1:0]       ba_turned;
    logic                  flip_next;
    logic [BA_W-1:0]       ba_folded;

    always_comb
    begin
        ba = {s2_q_reg[BA_W-DEG_SHIFT-1:0], {DEG_SHIFT{1'b0}}}
             + BA_W'(FRAC_TAB[s2_r_reg]);
        ba_turned = ba + (BA_W'(1) << (BA_W - 2));
        flip_next = ba_turned[BA_W-1];
        ba_folded = flip_next ? {~ba[BA_W-1], ba[BA_W-2:0]} : ba;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg[0] <= 1'b0;
        end
        else
        begin
            c_v_reg[0] <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0]     <= X_INIT;
        cy_reg[0]     <= '0;
        z_reg[0]      <= ZW'(signed'(ba_folded));
        flip_reg[0]   <= flip_next;
        c_axis_reg[0] <= s2_axis_reg;
    end

    // ---------------------------------------------------------------------
    // CORDIC rotation, one iteration per stage.
    // ---------------------------------------------------------------------
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN_K = ZW'(ATAN_TAB[k]);
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = cy_reg[k] >>> k;
        assign dy = cx_reg[k] >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                c_v_reg[k+1] <= c_v_reg[k];
            end
        end

        // Rotate toward zero residual angle.
        always_ff @(posedge clk)
        begin
            if (!z_reg[k][ZW-1])
            begin
                cx_reg[k+1] <= cx_reg[k] - dx;
                cy_reg[k+1] <= cy_reg[k] + dy;
                z_reg[k+1]  <= z_reg[k] - ATAN_K;
            end
            else
            begin
                cx_reg[k+1] <= cx_reg[k] + dx;
                cy_reg[k+1] <= cy_reg[k] - dy;
                z_reg[k+1]  <= z_reg[k] + ATAN_K;
            end
            flip_reg[k+1]   <= flip_reg[k];
            c_axis_reg[k+1] <= c_axis_reg[k];
        end
    end

    // ---------------------------------------------------------------------
    // Undo the fold: negate cosine and sine when the angle was turned.
    // ---------------------------------------------------------------------
    logic                  fl_v_reg;
    logic signed [CW-1:0]  fl_c_reg;
    logic signed [CW-1:0]  fl_s_reg;
    axis_t                 fl_axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fl_v_reg <= 1'b0;
        end
        else
        begin
            fl_v_reg <= c_v_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (flip_reg[CORDIC_STAGES])
        begin
            fl_c_reg <= -cx_reg[CORDIC_STAGES];
            fl_s_reg <= -cy_reg[CORDIC_STAGES];
        end
        else
        begin
            fl_c_reg <= cx_reg[CORDIC_STAGES];
            fl_s_reg <= cy_reg[CORDIC_STAGES];
        end
        fl_axis_reg <= c_axis_reg[CORDIC_STAGES];
    end

    // ---------------------------------------------------------------------
    // Scale the axis by the sine of the half angle.
    // ---------------------------------------------------------------------
    logic                  sc_v_reg;
    logic signed [XW-1:0]  sc_x_reg;
    logic signed [XW-1:0]  sc_y_reg;
    logic signed [XW-1:0]  sc_z_reg;
    logic signed [CW-1:0]  sc_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_v_reg <= 1'b0;
        end
        else
        begin
            sc_v_reg <= fl_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sc_x_reg <= scale_mul(fl_axis_reg.x, fl_s_reg);
        sc_y_reg <= scale_mul(fl_axis_reg.y, fl_s_reg);
        sc_z_reg <= scale_mul(fl_axis_reg.z, fl_s_reg);
        sc_c_reg <= fl_c_reg;
    end

    // ---------------------------------------------------------------------
    // Nine products against the doubled scaled axis.
    // ---------------------------------------------------------------------
    logic                  pr_v_reg;
    logic signed [XW:0]    x2;
    logic signed [XW:0]    y2;
    logic signed [XW:0]    z2;
    logic signed [PW-1:0]  pr_xx_reg, pr_xy_reg, pr_xz_reg;
    logic signed [PW-1:0]  pr_yy_reg, pr_yz_reg, pr_zz_reg;
    logic signed [PW-1:0]  pr_wx_reg, pr_wy_reg, pr_wz_reg;

    assign x2 = {sc_x_reg, 1'b0};
    assign y2 = {sc_y_reg, 1'b0};
    assign z2 = {sc_z_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_v_reg <= 1'b0;
        end
        else
        begin
            pr_v_reg <= sc_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_xx_reg <= sc_x_reg * x2;
        pr_xy_reg <= sc_x_reg * y2;
        pr_xz_reg <= sc_x_reg * z2;
        pr_yy_reg <= sc_y_reg * y2;
        pr_yz_reg <= sc_y_reg * z2;
        pr_zz_reg <= sc_z_reg * z2;
        pr_wx_reg <= sc_c_reg * x2;
        pr_wy_reg <= sc_c_reg * y2;
        pr_wz_reg <= sc_c_reg * z2;
    end

    // ---------------------------------------------------------------------
    // Round every product back to the internal format.
    // ---------------------------------------------------------------------
    logic                  rd_v_reg;
    logic signed [PW-1:0]  rd_xx_reg, rd_xy_reg, rd_xz_reg;
    logic signed [PW-1:0]  rd_yy_reg, rd_yz_reg, rd_zz_reg;
    logic signed [PW-1:0]  rd_wx_reg, rd_wy_reg, rd_wz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= pr_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_xx_reg <= round_ib(pr_xx_reg);
        rd_xy_reg <= round_ib(pr_xy_reg);
        rd_xz_reg <= round_ib(pr_xz_reg);
        rd_yy_reg <= round_ib(pr_yy_reg);
        rd_yz_reg <= round_ib(pr_yz_reg);
        rd_zz_reg <= round_ib(pr_zz_reg);
        rd_wx_reg <= round_ib(pr_wx_reg);
        rd_wy_reg <= round_ib(pr_wy_reg);
        rd_wz_reg <= round_ib(pr_wz_reg);
    end

    // ---------------------------------------------------------------------
    // Form the nine matrix entries at internal precision.
    // ---------------------------------------------------------------------
    logic                  sm_v_reg;
    logic signed [SW-1:0]  e00_reg, e01_reg, e02_reg;
    logic signed [SW-1:0]  e10_reg, e11_reg, e12_reg;
    logic signed [SW-1:0]  e20_reg, e21_reg, e22_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_v_reg <= 1'b0;
        end
        else
        begin
            sm_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e00_reg <= ONE_Q - (SW'(rd_yy_reg) + SW'(rd_zz_reg));
        e01_reg <= SW'(rd_xy_reg) - SW'(rd_wz_reg);
        e02_reg <= SW'(rd_xz_reg) + SW'(rd_wy_reg);
        e10_reg <= SW'(rd_xy_reg) + SW'(rd_wz_reg);
        e11_reg <= ONE_Q - (SW'(rd_xx_reg) + SW'(rd_zz_reg));
        e12_reg <= SW'(rd_yz_reg) - SW'(rd_wx_reg);
        e20_reg <= SW'(rd_xz_reg) - SW'(rd_wy_reg);
        e21_reg <= SW'(rd_yz_reg) + SW'(rd_wx_reg);
        e22_reg <= ONE_Q - (SW'(rd_xx_reg) + SW'(rd_yy_reg));
    end

    // ---------------------------------------------------------------------
    // Output register: round off guard bits and saturate.
    // ---------------------------------------------------------------------
    logic                        done_reg;
    logic signed [FIELD_W-1:0]   m00_reg, m01_reg, m02_reg;
    logic signed [FIELD_W-1:0]   m10_reg, m11_reg, m12_reg;
    logic signed [FIELD_W-1:0]   m20_reg, m21_reg, m22_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sm_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m00_reg <= sat_out(e00_reg);
        m01_reg <= sat_out(e01_reg);
        m02_reg <= sat_out(e02_reg);
        m10_reg <= sat_out(e10_reg);
        m11_reg <= sat_out(e11_reg);
        m12_reg <= sat_out(e12_reg);
        m20_reg <= sat_out(e20_reg);
        m21_reg <= sat_out(e21_reg);
        m22_reg <= sat_out(e22_reg);
    end

    assign done = done_reg;
    assign m00  = m00_reg;
    assign m01  = m01_reg;
    assign m02  = m02_reg;
    assign m10  = m10_reg;
    assign m11  = m11_reg;
    assign m12  = m12_reg;
    assign m20  = m20_reg;
    assign m21  = m21_reg;
    assign m22  = m22_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------

    // Every accepted request comes out after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted request did not produce a result on time");

    // No result without a request accepted the latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching request");

    // The remainder after the correction step is below 45.
    a_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        s2_v_reg |-> (s2_r_reg < R_W'(DEG_DIV)))
        else $error("angle remainder out of range");

    // The folded angle lies within a quarter turn either way.
    a_fold: assert property (@(posedge clk) disable iff (!rst_n)
        c_v_reg[0] |-> (z_reg[0] >= -Z_QUARTER && z_reg[0] < Z_QUARTER))
        else $error("folded angle outside [-90, 90) degrees");

endmodule

@@ tb/sv/tb_axis_angle_to_rotation_matrix_core.sv @@
// Self-checking testbench for the axis-angle to rotation matrix core.
// Each request is predicted in fixed point and compared entry by entry
// with the strobed result. Depends on aarm_pkg and the core module.
module tb_axis_angle_to_rotation_matrix_core;

    timeunit 1ns;
    timeprecision 1ps;

    import aarm_pkg::FIELD_W;

    localparam int FRAC_BITS   = 14;
    localparam int STAGES      = 16;
    localparam int INT_BITS    = FRAC_BITS + 4;
    localparam int LATENCY     = STAGES + 9;
    localparam longint GAIN_Q32 = 64'sd2608131496;

    // Arctangent of 2^-i as a fraction of a full turn scaled by 2^32.
    localparam longint ARCTAN_Q32 [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // Nine entries, m00 in the lowest slot, row-major.
    typedef logic [8:0][FIELD_W-1:0] matrix_t;

    localparam string ENTRY_NAMES [9] = '{
        "m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [FIELD_W-1:0] angle_deg = '0;
    logic signed [FIELD_W-1:0] axis_x = '0;
    logic signed [FIELD_W-1:0] axis_y = '0;
    logic signed [FIELD_W-1:0] axis_z = '0;
    logic busy;
    logic done;
    logic signed [FIELD_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    matrix_t pending_matrices [$];
    int      error_count = 0;

    axis_angle_to_rotation_matrix_core #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (STAGES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .angle_deg (angle_deg),
        .axis_x    (axis_x),
        .axis_y    (axis_y),
        .axis_z    (axis_z),
        .done      (done),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22)
    );

    always #6 clk = ~clk;

    // Rounded fixed-point product: add half an LSB, then floor shift.
    function automatic longint mul_round(longint a, longint b, int f);
        return (a * b + (64'sd1 << (f - 1))) >>> f;
    endfunction

    // Drop the guard bits with rounding and clamp to 16 bits.
    function automatic logic [FIELD_W-1:0] to_entry(longint v);
        longint r;
        r = (v + 64'sd8) >>> 4;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[FIELD_W-1:0];
    endfunction

    function automatic matrix_t rotation_from_axis_angle(
        logic signed [FIELD_W-1:0] ang,
        logic signed [FIELD_W-1:0] ax,
        logic signed [FIELD_W-1:0] ay,
        logic signed [FIELD_W-1:0] az
    );
        longint      a, z, c, s, dc, ds, one;
        longint      x, y, w, x2, y2, w2;
        longint      xx, xy, xw, yy, yw, ww, cx, cy, cw;
        logic [31:0] turn, folded;
        logic        flip;
        matrix_t     m;
        a = ang;
        // Half angle as a binary angle, offset by a full turn first.
        turn = 32'(((a + 64'sd46080) * 64'sd4194304 + 64'sd22) / 64'sd45);
        // Fold the back half of the circle into [-90, 90) degrees.
        folded = turn + 32'h4000_0000;
        flip = folded[31];
        if (flip)
            turn = turn + 32'h8000_0000;
        z = longint'(signed'(turn));
        c = GAIN_Q32 >>> (32 - INT_BITS);
        s = 0;
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            dc = s >>> i;
            ds = c >>> i;
            if (z >= 0)
            begin
                c = c - dc;
                s = s + ds;
                z = z - ARCTAN_Q32[i];
            end
            else
            begin
                c = c + dc;
                s = s - ds;
                z = z + ARCTAN_Q32[i];
            end
        end
        if (flip)
        begin
            c = -c;
            s = -s;
        end
        // Scaled axis and the doubled products.
        x = mul_round(longint'(ax), s, FRAC_BITS);
        y = mul_round(longint'(ay), s, FRAC_BITS);
        w = mul_round(longint'(az), s, FRAC_BITS);
        x2 = 2 * x;
        y2 = 2 * y;
        w2 = 2 * w;
        xx = mul_round(x, x2, INT_BITS);
        xy = mul_round(x, y2, INT_BITS);
        xw = mul_round(x, w2, INT_BITS);
        yy = mul_round(y, y2, INT_BITS);
        yw = mul_round(y, w2, INT_BITS);
        ww = mul_round(w, w2, INT_BITS);
        cx = mul_round(c, x2, INT_BITS);
        cy = mul_round(c, y2, INT_BITS);
        cw = mul_round(c, w2, INT_BITS);
        one = 64'sd1 << INT_BITS;
        m[0] = to_entry(one - (yy + ww));
        m[1] = to_entry(xy - cw);
        m[2] = to_entry(xw + cy);
        m[3] = to_entry(xy + cw);
        m[4] = to_entry(one - (xx + ww));
        m[5] = to_entry(yw - cx);
        m[6] = to_entry(xw - cy);
        m[7] = to_entry(yw + cx);
        m[8] = to_entry(one - (xx + yy));
        return m;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Present one request and hold it until the core takes it.
    task automatic issue_request(
        logic signed [FIELD_W-1:0] ang,
        logic signed [FIELD_W-1:0] ax,
        logic signed [FIELD_W-1:0] ay,
        logic signed [FIELD_W-1:0] az
    );
        matrix_t predicted;
        predicted = rotation_from_axis_angle(ang, ax, ay, az);
        start     <= 1'b1;
        angle_deg <= ang;
        axis_x    <= ax;
        axis_y    <= ay;
        axis_z    <= az;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_matrices.push_back(predicted);
    endtask

    // Keep start low while each cycle draws idle with the given percentage chance.
    task automatic maybe_idle(int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Compare every strobed result against the oldest prediction.
    always @(posedge clk)
    begin
        matrix_t got, want;
        if (rst_n && done === 1'b1)
        begin
            got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
            if (pending_matrices.size() == 0)
                report_mismatch("result strobe with no request outstanding");
            else
            begin
                want = pending_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                begin
                    if (got[k] !== want[k])
                        report_mismatch($sformatf("%s got %0d expected %0d",
                            ENTRY_NAMES[k], $signed(got[k]), $signed(want[k])));
                end
            end
        end
    end

    // Extreme angles, unit axes, degenerate and oversized axes.
    task automatic test_directed();
        issue_request(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        issue_request(16'sd5760, 16'sd16384, 16'sd0, 16'sd0);
        issue_request(16'sd5760, 16'sd0, 16'sd16384, 16'sd0);
        issue_request(16'sd5760, 16'sd0, 16'sd0, 16'sd16384);
        issue_request(16'sd11520, 16'sd0, 16'sd0, 16'sd16384);
        issue_request(-16'sd11520, 16'sd0, -16'sd16384, 16'sd0);
        issue_request(16'sd17280, -16'sd16384, 16'sd0, 16'sd0);
        issue_request(16'sd23040, 16'sd9459, 16'sd9459, 16'sd9459);
        issue_request(-16'sd23040, 16'sd9459, -16'sd9459, 16'sd9459);
        issue_request(16'sh7FFF, 16'sd0, 16'sd0, 16'sd16384);
        issue_request(16'sh8000, 16'sd16384, 16'sd0, 16'sd0);
        issue_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        issue_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        // Axis not of unit length: used as given, entries saturate.
        issue_request(16'sd11520, 16'sd16384, 16'sd16384, 16'sd16384);
        issue_request(16'sd5760, -16'sd16384, 16'sd16384, -16'sd16384);
        // Axis component of -2.0.
        issue_request(16'sd7680, 16'sh8000, 16'sd0, 16'sd0);
        issue_request(16'sd3840, 16'sd0, 16'sh8000, 16'sd16384);
        // Zero axis leaves the identity.
        issue_request(16'sd2880, 16'sd0, 16'sd0, 16'sd0);
        // Angle wrap: 360 degrees apart along the same axis.
        issue_request(16'sd1000, 16'sd0, 16'sd16384, 16'sd0);
        issue_request(16'sd1000 + 16'sd23040, 16'sd0, 16'sd16384, 16'sd0);
        issue_request(-16'sd1, 16'shFFFF, 16'shFFFF, 16'shFFFF);
        issue_request(16'sd1, 16'sd1, 16'sd1, 16'sd1);
    endtask

    // Mostly unit axes with random angles, plus extremes and raw noise.
    task automatic test_random_traffic(int idle_pct, int count);
        int  rx, ry, rz;
        real norm;
        logic signed [FIELD_W-1:0] ang, ax, ay, az;
        for (int n = 0; n < count; n++)
        begin
            ang = FIELD_W'($urandom);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    ax = FIELD_W'($urandom);
                    ay = FIELD_W'($urandom);
                    az = FIELD_W'($urandom);
                end
                2:
                begin
                    ax = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                    ay = $urandom_range(1) ? 16'sh8000 : 16'sd0;
                    az = $urandom_range(1) ? 16'sd16384 : 16'sh7FFF;
                    ang = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                end
                default:
                begin
                    rx = int'($urandom_range(0, 32768)) - 16384;
                    ry = int'($urandom_range(0, 32768)) - 16384;
                    rz = int'($urandom_range(0, 32768)) - 16384;
                    norm = $sqrt(real'(rx) * rx + real'(ry) * ry + real'(rz) * rz);
                    if (norm < 1.0)
                    begin
                        rx = 16384;
                        norm = 16384.0;
                    end
                    ax = FIELD_W'($rtoi(rx * 16384.0 / norm));
                    ay = FIELD_W'($rtoi(ry * 16384.0 / norm));
                    az = FIELD_W'($rtoi(rz * 16384.0 / norm));
                end
            endcase
            issue_request(ang, ax, ay, az);
            maybe_idle(idle_pct);
        end
    endtask

    // Send traffic, stop sending until every outstanding result has come back, then send again.
    task automatic test_drain_pause();
        test_random_traffic(0, 10);
        start <= 1'b0;
        while (pending_matrices.size() != 0)
            @(posedge clk);
        test_random_traffic(0, 10);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_random_traffic(0, 440);
        test_random_traffic(59, 440);
        test_drain_pause();
        test_random_traffic(0, 420);
        test_random_traffic(24, 440);
        start <= 1'b0;
        while (pending_matrices.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
